[design/kwft_pkg.sv]
`timescale 1ns / 1ps
package kwft_pkg;
	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_GET = 2'd1;
	localparam logic [1:0] OP_COH = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [16:0] COH_ONE = 17'd65536;
	localparam logic [16:0] COH_HALF = 17'd32768;
	localparam int ENTRY_W = 96;
endpackage

[design/kwft_ram.sv]
`timescale 1ns / 1ps
module kwft_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/kwft_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, 64-bit dividend by DIV_W-bit divisor
module kwft_div #(
	parameter int DIV_W = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic [6:0]       cnt_q;
	logic             run_q;
	logic [DIV_W:0]   rem_q;
	logic [63:0]      quo_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W+1:0] trial;
	logic [DIV_W:0]   shifted;

	assign shifted = {rem_q[DIV_W-1:0], quo_q[63]};
	assign trial = {1'b0, shifted} - {2'b0, div_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			if (!trial[DIV_W+1]) begin
				rem_q <= trial[DIV_W:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

[design/keyed_weighted_fusion_table_top.sv]
`timescale 1ns / 1ps
// Keyed table of Q16.16 value/precision estimates held in one synchronous RAM.
// An item is taken when start is high and busy low; its single result appears
// for one cycle with done high and cannot be held off. Each set, get or
// coherence request scans the stored entries one per cycle through the RAM
// read port, a set or get stopping at its key; a merge adds the bit-serial
// divider and a write-back, and a coherence request scans all entries with
// one multiply per entry then runs the same divider; other operations skip the scan.
module keyed_weighted_fusion_table_top #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] key_tag,
	input  logic signed [31:0] new_value,
	input  logic [31:0] new_precision,
	output logic        done,
	output logic [1:0]  status,
	output logic signed [31:0] found_value,
	output logic [31:0] found_precision,
	output logic [16:0] coherence,
	output logic [31:0] table_version
);
	import kwft_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int TPW = 32 + CW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0]  state_q;
	logic [1:0]  op_q;
	logic [31:0] key_q, val_q, prec_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ridx_q;
	logic        rv_s1;
	logic [AW-1:0] idx_s1;
	logic [AW-1:0] hit_q;
	logic        found_q;
	logic [31:0] version_q;
	logic [16:0] coh_q;
	logic [31:0] v0_q;
	logic        neg_q;
	logic [32:0] tot_q;
	logic signed [97:0] acc_q;
	logic [TPW-1:0] tp_q;
	logic [63:0] prod_q;
	logic        prod_neg_q, prod_v_q;

	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;
	logic        div_start, div_done;
	logic [63:0] div_a, quo;
	logic [TPW-1:0] div_b;
	logic [TPW-1:0] den;

	kwft_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	kwft_div #(.DIV_W(TPW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(quo)
	);

	assign busy = (state_q != S_IDLE);
	assign raddr = ridx_q[AW-1:0];
	assign coherence = coh_q;
	assign table_version = version_q;

	// merge divides by the summed pair, coherence by the full precision total
	assign den = (op_q == OP_SET) ? TPW'(tot_q) : tp_q;

	logic signed [32:0] diff;
	logic [32:0] mag;
	logic [31:0] rv_val, rv_prec;
	logic [31:0] amag;
	logic [97:0] amagw;
	logic [63:0] mean_hi;

	assign rv_val = rdata[63:32];
	assign rv_prec = rdata[31:0];
	assign diff = $signed({val_q[31], val_q}) - $signed({v0_q[31], v0_q});
	assign mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign amagw = acc_q[97] ? 98'(-acc_q) : 98'(acc_q);
	assign amag = 32'(rv_val[31] ? -rv_val : rv_val);

	always_comb begin
		div_a = '0;
		div_b = den;
		if (op_q == OP_SET) begin
			div_a = 64'(mag) * 64'(prec_q);
		end else begin
			div_a = amagw[63:0];
		end
	end

	logic [32:0] set_val;
	assign mean_hi = quo;
	assign set_val = neg_q ? 33'({v0_q[31], v0_q} - mean_hi[32:0])
		: 33'({v0_q[31], v0_q} + mean_hi[32:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			version_q <= '0;
			coh_q <= COH_HALF;
			done <= 1'b0;
			rv_s1 <= 1'b0;
			prod_v_q <= 1'b0;
		end else begin
			done <= 1'b0;
			rv_s1 <= 1'b0;
			prod_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (operation == OP_SET || operation == OP_GET
							|| operation == OP_COH) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: begin
					if (ridx_q < count_q && !(found_q && op_q != OP_COH)) begin
						rv_s1 <= 1'b1;
					end
					if (op_q == OP_COH) begin
						prod_v_q <= rv_s1;
						if (!rv_s1 && !prod_v_q && ridx_q >= count_q) begin
							state_q <= S_DIV;
						end
					end else if (found_q || (!rv_s1 && ridx_q >= count_q)) begin
						if (op_q == OP_SET && found_q) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_OUT;
							if (op_q == OP_SET && CW'(count_q) < CW'(TABLE_ENTRIES)) begin
								count_q <= count_q + 1'b1;
								version_q <= version_q + 32'd1;
							end
						end
					end
				end
				S_DIV: begin
					if (div_done || den == '0) begin
						state_q <= S_OUT;
						if (op_q == OP_SET) begin
							version_q <= version_q + 32'd1;
						end else if (den == '0) begin
							coh_q <= '0;
						end else if (amagw[97:64] != '0
							|| amagw[63:0] >= 64'({tp_q, 16'd0})) begin
							coh_q <= COH_ONE;
						end else begin
							coh_q <= quo[16:0];
						end
					end
				end
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divider launched on the first cycle in the division state
	logic div_go_q;
	assign div_start = (state_q == S_DIV) && !div_go_q && den != '0;

	always_ff @(posedge clk) begin
		we <= 1'b0;
		div_go_q <= (state_q == S_DIV);
		case (state_q)
			S_IDLE: begin
				op_q <= operation;
				key_q <= key_tag;
				val_q <= new_value;
				prec_q <= new_precision;
				ridx_q <= '0;
				found_q <= 1'b0;
				acc_q <= '0;
				tp_q <= '0;
				status <= ST_OK;
				found_value <= '0;
				found_precision <= '0;
			end
			S_SCAN: begin
				if (ridx_q < count_q && !(found_q && op_q != OP_COH)) begin
					ridx_q <= ridx_q + 1'b1;
				end
				idx_s1 <= ridx_q[AW-1:0];
				if (op_q == OP_COH) begin
					if (rv_s1) begin
						prod_q <= 64'(amag) * 64'(rv_prec);
						prod_neg_q <= rv_val[31];
						tp_q <= tp_q + TPW'(rv_prec);
					end
					if (prod_v_q) begin
						acc_q <= prod_neg_q ? acc_q - $signed({34'd0, prod_q})
							: acc_q + $signed({34'd0, prod_q});
					end
				end else if (rv_s1 && !found_q && rdata[95:64] == key_q) begin
					found_q <= 1'b1;
					hit_q <= idx_s1;
					v0_q <= rv_val;
					tot_q <= 33'(rv_prec) + 33'(prec_q);
					found_value <= rv_val;
					found_precision <= rv_prec;
				end else if (!found_q && !rv_s1 && ridx_q >= count_q) begin
					if (op_q == OP_GET) begin
						status <= ST_NOT_FOUND;
					end else if (CW'(count_q) < CW'(TABLE_ENTRIES)) begin
						we <= 1'b1;
						waddr <= count_q[AW-1:0];
						wdata <= {key_q, val_q, prec_q};
						found_value <= val_q;
						found_precision <= prec_q;
					end else begin
						status <= ST_FULL;
					end
				end
				if (found_q) begin
					neg_q <= diff[32];
				end
			end
			S_DIV: begin
				if (op_q == OP_SET && (div_done || tot_q == '0)) begin
					we <= 1'b1;
					waddr <= hit_q;
					wdata[95:64] <= key_q;
					wdata[63:32] <= (tot_q == '0) ? v0_q : set_val[31:0];
					wdata[31:0] <= tot_q[32] ? 32'hFFFF_FFFF : tot_q[31:0];
					found_value <= (tot_q == '0) ? v0_q : set_val[31:0];
					found_precision <= tot_q[32] ? 32'hFFFF_FFFF : tot_q[31:0];
				end
				if (op_q == OP_COH) begin
					found_value <= '0;
					found_precision <= '0;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
